[sv/gdev_pkg.sv]
// Package of shared constants, codes and helpers for the grid diffusion block.
`timescale 1ns / 1ps

package gdev_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int SWW        = $clog2(MAX_WIDTH + 1);
  localparam int SHW        = $clog2(MAX_HEIGHT + 1);
  localparam int CELL_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);

  localparam logic [14:0] FULL_SHARE = 15'd16384;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_GET  = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_EVAP   = 3'd2;
  localparam logic [2:0] REG_DIFF   = 3'd3;
  localparam logic [2:0] REG_MAX    = 3'd4;

  localparam logic [6:0]  RST_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_HEIGHT = 7'd64;
  localparam logic [15:0] RST_EVAP   = 16'd64880;
  localparam logic [14:0] RST_DIFF   = 15'd655;
  localparam logic [15:0] RST_MAX    = 16'd65535;

  function automatic logic [CELL_AW-1:0] cell_addr(logic [YW-1:0] y, logic [XW-1:0] x);
    return CELL_AW'(CELL_AW'(y) * CELL_AW'(MAX_WIDTH)) + CELL_AW'(x);
  endfunction

  // Next line buffer in the three-way rotation.
  function automatic logic [1:0] rot(logic [1:0] r);
    return (r == 2'd2) ? 2'd0 : 2'(r + 2'd1);
  endfunction

endpackage

[sv/gdev_if.sv]
// Channel interfaces for requests, results and register writes.
`timescale 1ns / 1ps

interface gdev_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  x_pos;
  logic [7:0]  y_pos;
  logic [15:0] strength;
  modport source (output valid, action, x_pos, y_pos, strength, input ready);
  modport sink   (input valid, action, x_pos, y_pos, strength, output ready);
endinterface

interface gdev_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] level;
  logic        in_range;
  modport source (output valid, level, in_range, input ready);
  modport sink   (input valid, level, in_range, output ready);
endinterface

interface gdev_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/gdev_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gdev_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/grid_diffusion_evaporation.sv]
// Grid of decaying, diffusing Q8.8 levels held in a cell RAM with line buffers.
//
//  channel | dir | handshake     | payload
//  req_i   | in  | valid / ready | action, x_pos, y_pos, strength
//  res_o   | out | valid / ready | level, in_range
//  cfg_i   | in  | valid / ready | index, data (ready is always high)
//
// After reset a clearing pass writes zero to all 4096 cells, one per cycle, and
// no request is taken during it. An add or read request passes through the cell
// and finish states, and one whose coordinates are out of range goes straight to
// the finish state. A tick first decays every row into a line buffer through the
// single cell RAM read port, then filters the row and writes it back. A request
// is taken only in the idle state; a result waits in the output register while
// the next request is accepted.
`timescale 1ns / 1ps

module grid_diffusion_evaporation (
  input  logic            clk_i,
  input  logic            rst_ni,
  gdev_req_if.sink        req_i,
  gdev_res_if.source      res_o,
  gdev_cfg_if.sink        cfg_i
);

  localparam int AW = gdev_pkg::SWW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_CELL, ST_LOAD, ST_CALC, ST_FIN
  } state_e;

  state_e state_q;

  logic [6:0]  cfg_w_q, cfg_h_q;
  logic [15:0] evap_q, max_q;
  logic [14:0] diff_q;

  logic [gdev_pkg::CELL_AW-1:0] clr_q, op_addr_q;
  logic                         op_add_q;
  logic [15:0]                  op_str_q;
  logic [15:0]                  res_level_q, out_level_q;
  logic                         res_ok_q, out_ok_q, out_v_q;

  logic [gdev_pkg::YW-1:0] y_q;
  logic [1:0]              r_q;
  logic                    load_first_q;
  logic [AW-1:0]           a_q;

  logic                    l1_v_q, l2_v_q;
  logic [gdev_pkg::XW-1:0] l1_x_q, l2_x_q;
  logic [15:0]             dec_q;

  logic                    c1_v_q, c2_v_q;
  logic [AW-1:0]           c1_a_q;
  logic [gdev_pkg::XW-1:0] c2_x_q;
  logic [15:0]             cur_left_q, cur_mid_q, ab_q, be_q;
  logic [32:0]             pc_q, pd_q;

  // Effective sizes and weights.
  logic [31:0]              w_full, h_full;
  logic [gdev_pkg::SWW-1:0] w;
  logic [gdev_pkg::SHW-1:0] h;
  logic [14:0]              d_eff;
  logic [16:0]              c_w;
  logic                     more_rows, in_grid;

  always_comb begin
    if (cfg_w_q == 7'd0) w_full = 32'd1;
    else if (32'(cfg_w_q) > 32'(gdev_pkg::MAX_WIDTH)) w_full = 32'(gdev_pkg::MAX_WIDTH);
    else w_full = 32'(cfg_w_q);
    if (cfg_h_q == 7'd0) h_full = 32'd1;
    else if (32'(cfg_h_q) > 32'(gdev_pkg::MAX_HEIGHT)) h_full = 32'(gdev_pkg::MAX_HEIGHT);
    else h_full = 32'(cfg_h_q);
  end

  assign w         = w_full[gdev_pkg::SWW-1:0];
  assign h         = h_full[gdev_pkg::SHW-1:0];
  assign d_eff     = (diff_q > gdev_pkg::FULL_SHARE) ? gdev_pkg::FULL_SHARE : diff_q;
  assign c_w       = 17'(18'h10000 - {1'b0, d_eff, 2'b00});
  assign more_rows = (32'(y_q) + 32'd1) < 32'(h);
  assign in_grid   = (32'(req_i.x_pos) < 32'(w)) && (32'(req_i.y_pos) < 32'(h));

  // Cell RAM.
  logic                         cell_we;
  logic [gdev_pkg::CELL_AW-1:0] cell_wa, cell_ra;
  logic [15:0]                  cell_wd, cell_rd;
  logic [16:0]                  add_sum;
  logic [15:0]                  add_sat;
  logic [33:0]                  st_sum;
  logic [17:0]                  st_res;
  logic [gdev_pkg::YW-1:0]      load_row;

  assign add_sum  = 17'(cell_rd) + 17'(op_str_q);
  assign add_sat  = (add_sum > 17'(max_q)) ? max_q : add_sum[15:0];
  assign st_sum   = 34'(pc_q) + 34'(pd_q);
  assign st_res   = st_sum[33:16];
  assign load_row = load_first_q ? '0 : gdev_pkg::YW'(y_q + 1'b1);

  always_comb begin
    cell_we = 1'b0;
    cell_wa = '0;
    cell_wd = '0;
    cell_ra = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cell_we = 1'b1;
        cell_wa = clr_q;
      end
      ST_IDLE: begin
        cell_ra = gdev_pkg::cell_addr(req_i.y_pos[gdev_pkg::YW-1:0],
                                      req_i.x_pos[gdev_pkg::XW-1:0]);
      end
      ST_CELL: begin
        cell_we = op_add_q;
        cell_wa = op_addr_q;
        cell_wd = add_sat;
      end
      ST_LOAD: begin
        cell_ra = gdev_pkg::cell_addr(load_row, a_q[gdev_pkg::XW-1:0]);
      end
      ST_CALC: begin
        cell_we = c2_v_q;
        cell_wa = gdev_pkg::cell_addr(y_q, c2_x_q);
        cell_wd = (st_res[17:16] != 2'b00) ? 16'hFFFF : st_res[15:0];
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  gdev_ram #(.WIDTH(16), .DEPTH(gdev_pkg::CELL_DEPTH)) u_cells (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_wa),
    .wdata_i (cell_wd),
    .raddr_i (cell_ra),
    .rdata_o (cell_rd)
  );

  // Three line buffers rotate through the roles above, current and below.
  logic [1:0]  load_sel, sel_below, sel_above;
  logic [15:0] buf_rd [3];
  logic [15:0] rd_cur, rd_above, rd_below;

  assign load_sel  = load_first_q ? r_q : gdev_pkg::rot(r_q);
  assign sel_below = gdev_pkg::rot(r_q);
  assign sel_above = gdev_pkg::rot(sel_below);

  for (genvar i = 0; i < 3; i++) begin : g_line
    gdev_ram #(.WIDTH(16), .DEPTH(gdev_pkg::MAX_WIDTH)) u_line (
      .clk_i   (clk_i),
      .we_i    (l2_v_q && (load_sel == 2'(i))),
      .waddr_i (l2_x_q),
      .wdata_i (dec_q),
      .raddr_i (a_q[gdev_pkg::XW-1:0]),
      .rdata_o (buf_rd[i])
    );
  end

  assign rd_cur   = buf_rd[r_q];
  assign rd_above = buf_rd[sel_above];
  assign rd_below = buf_rd[sel_below];

  // Stencil operands for cell c1_a_q - 1.
  logic [15:0] op_left, op_right, op_up, op_down;
  logic [17:0] nsum;

  assign op_left  = (c1_a_q >= AW'(2)) ? cur_left_q : 16'd0;
  assign op_right = (c1_a_q < AW'(w)) ? rd_cur : 16'd0;
  assign op_up    = (y_q != '0) ? ab_q : 16'd0;
  assign op_down  = more_rows ? be_q : 16'd0;
  assign nsum     = 18'(op_left) + 18'(op_right) + 18'(op_up) + 18'(op_down);

  logic in_acc;
  assign in_acc      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid    = out_v_q;
  assign res_o.level    = out_level_q;
  assign res_o.in_range = out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      cfg_w_q      <= gdev_pkg::RST_WIDTH;
      cfg_h_q      <= gdev_pkg::RST_HEIGHT;
      evap_q       <= gdev_pkg::RST_EVAP;
      diff_q       <= gdev_pkg::RST_DIFF;
      max_q        <= gdev_pkg::RST_MAX;
      out_v_q      <= 1'b0;
      l1_v_q       <= 1'b0;
      l2_v_q       <= 1'b0;
      c1_v_q       <= 1'b0;
      c2_v_q       <= 1'b0;
      a_q          <= '0;
      y_q          <= '0;
      r_q          <= '0;
      load_first_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          gdev_pkg::REG_WIDTH:  cfg_w_q <= cfg_i.data[6:0];
          gdev_pkg::REG_HEIGHT: cfg_h_q <= cfg_i.data[6:0];
          gdev_pkg::REG_EVAP:   evap_q  <= cfg_i.data;
          gdev_pkg::REG_DIFF:   diff_q  <= cfg_i.data[14:0];
          gdev_pkg::REG_MAX:    max_q   <= cfg_i.data;
          default: begin
          end
        endcase
      end

      // The finish state loads the output register itself.
      if (res_o.ready && (state_q != ST_FIN)) out_v_q <= 1'b0;

      // Load pipeline: read cell, decay, write line buffer.
      l1_v_q <= (state_q == ST_LOAD) && (a_q < AW'(w));
      l1_x_q <= a_q[gdev_pkg::XW-1:0];
      l2_v_q <= l1_v_q;
      l2_x_q <= l1_x_q;
      dec_q  <= 16'((32'(cell_rd) * 32'(evap_q)) >> 16);

      // Filter pipeline: read line buffers, weight, write cell.
      c1_v_q <= (state_q == ST_CALC) && (a_q <= AW'(w));
      c1_a_q <= a_q;
      c2_v_q <= c1_v_q && (c1_a_q != '0);
      c2_x_q <= gdev_pkg::XW'(c1_a_q - 1'b1);
      if (c1_v_q) begin
        cur_left_q <= cur_mid_q;
        cur_mid_q  <= rd_cur;
        ab_q       <= rd_above;
        be_q       <= rd_below;
        pc_q       <= 33'(cur_mid_q) * 33'(c_w);
        pd_q       <= 33'(nsum) * 33'(d_eff);
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= gdev_pkg::CELL_AW'(clr_q + 1'b1);
          if (clr_q == '1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            op_addr_q <= gdev_pkg::cell_addr(req_i.y_pos[gdev_pkg::YW-1:0],
                                             req_i.x_pos[gdev_pkg::XW-1:0]);
            op_str_q  <= req_i.strength;
            op_add_q  <= (gdev_pkg::action_e'(req_i.action) == gdev_pkg::ACT_ADD);
            unique case (gdev_pkg::action_e'(req_i.action))
              gdev_pkg::ACT_ADD, gdev_pkg::ACT_GET: begin
                res_level_q <= 16'd0;
                res_ok_q    <= 1'b0;
                state_q     <= in_grid ? ST_CELL : ST_FIN;
              end
              gdev_pkg::ACT_TICK: begin
                y_q          <= '0;
                r_q          <= '0;
                a_q          <= '0;
                load_first_q <= 1'b1;
                state_q      <= ST_LOAD;
              end
              default: begin
                res_level_q <= 16'd0;
                res_ok_q    <= 1'b0;
                state_q     <= ST_FIN;
              end
            endcase
          end
        end
        ST_CELL: begin
          res_level_q <= op_add_q ? 16'd0 : cell_rd;
          res_ok_q    <= 1'b1;
          state_q     <= ST_FIN;
        end
        ST_LOAD: begin
          if (a_q < AW'(w)) begin
            a_q <= AW'(a_q + 1'b1);
          end else if (!l1_v_q && !l2_v_q) begin
            a_q <= '0;
            load_first_q <= 1'b0;
            // After row zero, the row below is loaded before filtering starts.
            state_q <= (load_first_q && more_rows) ? ST_LOAD : ST_CALC;
          end
        end
        ST_CALC: begin
          if (a_q <= AW'(w)) begin
            a_q <= AW'(a_q + 1'b1);
          end else if (!c1_v_q && !c2_v_q) begin
            a_q <= '0;
            if (more_rows) begin
              y_q     <= gdev_pkg::YW'(y_q + 1'b1);
              r_q     <= gdev_pkg::rot(r_q);
              state_q <= (32'(y_q) + 32'd2 < 32'(h)) ? ST_LOAD : ST_CALC;
            end else begin
              res_level_q <= 16'd0;
              res_ok_q    <= 1'b1;
              state_q     <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!out_v_q || res_o.ready) begin
            out_v_q     <= 1'b1;
            out_level_q <= res_level_q;
            out_ok_q    <= res_ok_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q == ST_FIN))
    else $error("result produced outside finish state");

  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> !l2_v_q)
    else $error("line buffer write while filtering");

  a_store_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_v_q |-> (state_q == ST_CALC))
    else $error("filtered cell written outside filter phase");

endmodule
